### hdl/wake_phrase_matcher_stripper_defines.svh
// Assertion macros used by the checker of the wake-phrase block.
`ifndef WAKE_PHRASE_MATCHER_STRIPPER_DEFINES_SVH
`define WAKE_PHRASE_MATCHER_STRIPPER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define WPM_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define WPM_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### hdl/wpm_pkg.sv
package wpm_pkg;

  localparam int NUM_RAW  = 9;
  localparam int NUM_FOLD = 6;
  localparam int MAX_PAT  = 12;

  localparam logic [7:0] ASCII_LIMIT = 8'd128;
  localparam logic [7:0] SEP_LEAD_A  = 8'hE3;
  localparam logic [7:0] SEP_MID_A   = 8'h80;
  localparam logic [7:0] SEP_TAIL_A  = 8'h81;
  localparam logic [7:0] SEP_LEAD_B  = 8'hEF;
  localparam logic [7:0] SEP_MID_B   = 8'hBC;
  localparam logic [7:0] SEP_TAIL_B  = 8'h8C;

  localparam logic [3:0] RAW_LEN [NUM_RAW] = '{
    4'd12, 4'd11, 4'd11, 4'd12, 4'd12, 4'd12, 4'd12, 4'd11, 4'd12};

  localparam logic [7:0] RAW_PAT [NUM_RAW][MAX_PAT] = '{
    '{8'hE4, 8'hBD, 8'hA0, 8'hE5, 8'hA5, 8'hBD, 8'h20, 8'h6B, 8'h69, 8'h74, 8'h74, 8'h79},
    '{8'hE4, 8'hBD, 8'hA0, 8'hE5, 8'hA5, 8'hBD, 8'h4B, 8'h69, 8'h74, 8'h74, 8'h79, 8'h00},
    '{8'hE4, 8'hBD, 8'hA0, 8'hE5, 8'hA5, 8'hBD, 8'h6B, 8'h69, 8'h74, 8'h74, 8'h79, 8'h00},
    '{8'hE4, 8'hBD, 8'hA0, 8'hE5, 8'hA5, 8'hBD, 8'hE5, 8'h87, 8'hAF, 8'hE8, 8'h92, 8'h82},
    '{8'hE4, 8'hBD, 8'hA0, 8'hE5, 8'hA5, 8'hBD, 8'hE5, 8'hB0, 8'h8F, 8'hE7, 8'h8C, 8'hAB},
    '{8'h6E, 8'h69, 8'h20, 8'h68, 8'h61, 8'h6F, 8'h20, 8'h6B, 8'h69, 8'h74, 8'h74, 8'h79},
    '{8'h4E, 8'h69, 8'h20, 8'h68, 8'h61, 8'h6F, 8'h20, 8'h6B, 8'h69, 8'h74, 8'h74, 8'h79},
    '{8'h6E, 8'h69, 8'h68, 8'h61, 8'h6F, 8'h20, 8'h6B, 8'h69, 8'h74, 8'h74, 8'h79, 8'h00},
    '{8'h6E, 8'h69, 8'h20, 8'h68, 8'h61, 8'h6F, 8'h20, 8'h4B, 8'h69, 8'h74, 8'h74, 8'h79}};

  localparam int FOLD_LEN [NUM_FOLD] = '{11, 12, 12, 10, 10, 12};

  localparam logic [7:0] FOLD_PAT [NUM_FOLD][MAX_PAT] = '{
    '{8'hE4, 8'hBD, 8'hA0, 8'hE5, 8'hA5, 8'hBD, 8'h6B, 8'h69, 8'h74, 8'h74, 8'h79, 8'h00},
    '{8'hE4, 8'hBD, 8'hA0, 8'hE5, 8'hA5, 8'hBD, 8'hE5, 8'h87, 8'hAF, 8'hE8, 8'h92, 8'h82},
    '{8'hE4, 8'hBD, 8'hA0, 8'hE5, 8'hA5, 8'hBD, 8'hE5, 8'hB0, 8'h8F, 8'hE7, 8'h8C, 8'hAB},
    '{8'h6E, 8'h69, 8'h68, 8'h61, 8'h6F, 8'h6B, 8'h69, 8'h74, 8'h74, 8'h79, 8'h00, 8'h00},
    '{8'h6E, 8'h69, 8'h68, 8'h61, 8'h6F, 8'h6B, 8'h61, 8'h69, 8'h64, 8'h69, 8'h00, 8'h00},
    '{8'h6E, 8'h69, 8'h68, 8'h61, 8'h6F, 8'h78, 8'h69, 8'h61, 8'h6F, 8'h6D, 8'h61, 8'h6F}};

  // One queued job: the bytes one input item releases, plus an optional verdict
  typedef struct packed {
    logic [MAX_PAT-1:0][7:0] bytes;
    logic [3:0]              n_bytes;
    logic                    verdict;
    logic                    addressed;
  } job_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  function automatic logic bytes_equal(input logic [7:0] a, input logic [7:0] b);
    if (a < ASCII_LIMIT && b < ASCII_LIMIT) return to_lower(a) == to_lower(b);
    return a == b;
  endfunction

  function automatic logic is_plain_sep(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h2C || b == 8'h2E || b == 8'h21 || b == 8'h3F;
  endfunction

  function automatic logic is_fold_drop(input logic [7:0] b);
    return is_plain_sep(b) || b == 8'h3A || b == 8'h3B || b == 8'h27 || b == 8'h22;
  endfunction

endpackage

### hdl/wpm_in_if.sv
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

### hdl/wpm_out_if.sv
interface wpm_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] out_byte;
  logic       addressed;
  logic       last_result;

  modport source (output valid, result_kind, out_byte, addressed, last_result, input ready);
  modport sink (input valid, result_kind, out_byte, addressed, last_result, output ready);
endinterface

### hdl/wpm_front.sv
module wpm_front import wpm_pkg::*; #(
  parameter int MATCH_WINDOW = 12
) (
  input  logic     clk,
  input  logic     rst,
  wpm_in_if.sink   text_in,
  input  logic     q_full,
  output logic     job_push,
  output job_t     job
);

  localparam int FILL_W = $clog2(MATCH_WINDOW + 1);

  typedef enum logic [1:0] {S_PREFIX, S_STRIP, S_RAW, S_MATCHED} phase_t;

  phase_t              phase, phase_next;
  logic [7:0]          prefix_buffer [MAX_PAT];
  logic [3:0]          prefix_count, prefix_count_next;
  logic [NUM_RAW-1:0]  candidate_mask, candidate_mask_next;
  logic [7:0]          pending_separator [2];
  logic [1:0]          pending_count, pending_count_next;
  logic [7:0]          folded_window [MATCH_WINDOW];
  logic [7:0]          folded_window_next [MATCH_WINDOW];
  logic [FILL_W-1:0]   window_fill, window_fill_next;
  logic                phrase_found, phrase_found_next;

  logic       fire, drop, hit, fail, matched, buf_write, pend_write;
  logic [7:0] b;
  logic       eot;
  logic [NUM_RAW-1:0] len_hit;
  logic [FILL_W-1:0]  fill_cap;
  logic               ok;

  assign text_in.ready = !q_full;
  assign fire = text_in.valid && text_in.ready;
  assign b    = text_in.text_byte;
  assign eot  = text_in.end_of_text;
  assign drop = is_fold_drop(b);
  assign fill_cap = FILL_W'(MATCH_WINDOW);

  // Fold the byte into the window and search it for the folded phrases
  always_comb begin
    folded_window_next = folded_window;
    window_fill_next = window_fill;
    phrase_found_next = phrase_found;
    ok = 1'b0;
    if (!drop) begin
      for (int i = 0; i < MATCH_WINDOW - 1; i++) folded_window_next[i] = folded_window[i + 1];
      folded_window_next[MATCH_WINDOW - 1] = to_lower(b);
      if (window_fill < fill_cap) window_fill_next = window_fill + 1'b1;
      for (int k = 0; k < NUM_FOLD; k++) begin
        ok = (int'(window_fill_next) >= FOLD_LEN[k]);
        for (int j = 0; j < MAX_PAT; j++) begin
          if (j < FOLD_LEN[k]) begin
            if (folded_window_next[MATCH_WINDOW - FOLD_LEN[k] + j] != FOLD_PAT[k][j]) ok = 1'b0;
          end
        end
        if (ok) phrase_found_next = 1'b1;
      end
    end
  end

  // Narrow the prefix candidates by the current byte
  always_comb begin
    for (int i = 0; i < NUM_RAW; i++) begin
      candidate_mask_next[i] = candidate_mask[i] && (prefix_count < RAW_LEN[i]) &&
                               bytes_equal(b, RAW_PAT[i][prefix_count]);
      len_hit[i] = (RAW_LEN[i] == prefix_count + 4'd1);
    end
    hit  = |(candidate_mask_next & len_hit);
    fail = (candidate_mask_next == '0) || (prefix_count >= 4'd11);
  end

  // Classify the item and build the job for the back end
  always_comb begin
    phase_next = phase;
    prefix_count_next = prefix_count;
    pending_count_next = pending_count;
    buf_write = 1'b0;
    pend_write = 1'b0;
    job = '0;
    case (phase)
      S_PREFIX: begin
        for (int k = 0; k < MAX_PAT; k++)
          job.bytes[k] = (4'(k) < prefix_count) ? prefix_buffer[k] : b;
        if (hit) begin
          phase_next = S_STRIP;
        end else if (fail) begin
          job.n_bytes = prefix_count + 4'd1;
          phase_next = S_RAW;
        end else begin
          buf_write = 1'b1;
          prefix_count_next = prefix_count + 4'd1;
          if (eot) job.n_bytes = prefix_count + 4'd1;
        end
      end
      S_STRIP: begin
        job.bytes[0] = (pending_count == 2'd0) ? b : pending_separator[0];
        job.bytes[1] = (pending_count == 2'd2) ? pending_separator[1] : b;
        job.bytes[2] = b;
        if (pending_count == 2'd0) begin
          if (is_plain_sep(b)) begin
          end else if (b == SEP_LEAD_A || b == SEP_LEAD_B) begin
            pend_write = 1'b1;
            pending_count_next = 2'd1;
            // A lead byte at end of text is flushed as it is
            if (eot) job.n_bytes = 4'd1;
          end else begin
            job.n_bytes = 4'd1;
            phase_next = S_MATCHED;
          end
        end else if ((pending_count == 2'd1 &&
                      b == ((pending_separator[0] == SEP_LEAD_A) ? SEP_MID_A : SEP_MID_B)) ||
                     (pending_count == 2'd2 &&
                      b == ((pending_separator[0] == SEP_LEAD_A) ? SEP_TAIL_A : SEP_TAIL_B))) begin
          pend_write = 1'b1;
          pending_count_next = (pending_count == 2'd1) ? 2'd2 : 2'd0;
          if (eot && pending_count == 2'd1) job.n_bytes = 4'd2;
        end else begin
          job.n_bytes = {2'b00, pending_count} + 4'd1;
          pending_count_next = 2'd0;
          phase_next = S_MATCHED;
        end
      end
      default: begin
        job.bytes[0] = b;
        job.n_bytes = 4'd1;
      end
    endcase
    // Separator bytes held at end of text are flushed as they are
    if (phase == S_STRIP && pending_count == 2'd1 && pend_write && eot) begin
      job.bytes[0] = pending_separator[0];
      job.bytes[1] = b;
    end
    matched = (phase_next == S_STRIP) || (phase_next == S_MATCHED);
    job.verdict = eot;
    job.addressed = eot && (matched || phrase_found_next);
    job_push = fire && (eot || job.n_bytes != 4'd0);
  end

  // Hold state; return to reset after the last byte of a text
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= S_PREFIX;
      prefix_count <= '0;
      candidate_mask <= '1;
      pending_count <= '0;
      window_fill <= '0;
      phrase_found <= 1'b0;
      for (int i = 0; i < MATCH_WINDOW; i++) folded_window[i] <= '0;
    end else if (fire) begin
      if (eot) begin
        phase <= S_PREFIX;
        prefix_count <= '0;
        candidate_mask <= '1;
        pending_count <= '0;
        window_fill <= '0;
        phrase_found <= 1'b0;
        for (int i = 0; i < MATCH_WINDOW; i++) folded_window[i] <= '0;
      end else begin
        phase <= phase_next;
        prefix_count <= prefix_count_next;
        candidate_mask <= candidate_mask_next;
        pending_count <= pending_count_next;
        window_fill <= window_fill_next;
        phrase_found <= phrase_found_next;
        folded_window <= folded_window_next;
      end
    end
  end

  // Payload stores, written before they are read
  always_ff @(posedge clk) begin
    if (fire && buf_write) prefix_buffer[prefix_count] <= b;
    if (fire && pend_write) pending_separator[pending_count[0]] <= b;
  end

endmodule

### hdl/wpm_queue.sv
module wpm_queue import wpm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

### hdl/wpm_back.sv
module wpm_back import wpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  job_t      head,
  output logic      pop,
  wpm_out_if.source result_out
);

  logic [3:0] idx;
  logic       at_verdict, last, fire;

  assign at_verdict = (idx == head.n_bytes);
  assign last = at_verdict || (!head.verdict && idx + 4'd1 == head.n_bytes);

  // Present the current result of the head job
  assign result_out.valid       = !empty;
  assign result_out.result_kind = at_verdict;
  assign result_out.out_byte    = at_verdict ? 8'h00 : head.bytes[idx];
  assign result_out.addressed   = at_verdict && head.addressed;
  assign result_out.last_result = last;

  assign fire = result_out.valid && result_out.ready;
  assign pop  = fire && last;

  // Advance through the job, restart on the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= last ? 4'd0 : idx + 4'd1;
    end
  end

endmodule

### hdl/wake_phrase_matcher_stripper.sv
// Channel     Dir  Payload
// text_in     in   text_byte[7:0], end_of_text
// result_out  out  result_kind, out_byte[7:0], addressed, last_result
//
// One input item per cycle is accepted while the two-job queue has room.
// Each item yields 0 to 13 results, drained from the queue head one per cycle while
// the receiver is ready; a flush of the prefix buffer backs up the input.
// Reset (rst, synchronous) clears state; no clearing pass is needed.
// Output stalls hold the head result; input keeps flowing until the queue fills.
module wake_phrase_matcher_stripper import wpm_pkg::*; #(
  parameter int MATCH_WINDOW = 12
) (
  input  logic      clk,
  input  logic      rst,
  wpm_in_if.sink    text_in,
  wpm_out_if.source result_out
);

  logic q_full, q_empty, q_push, q_pop;
  job_t push_job, head_job;

  wpm_front #(.MATCH_WINDOW(MATCH_WINDOW)) u_front (
    .clk(clk), .rst(rst), .text_in(text_in),
    .q_full(q_full), .job_push(q_push), .job(push_job)
  );

  wpm_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_job(push_job), .pop(q_pop),
    .full(q_full), .empty(q_empty), .head(head_job)
  );

  wpm_back u_back (
    .clk(clk), .rst(rst), .empty(q_empty), .head(head_job), .pop(q_pop),
    .result_out(result_out)
  );

endmodule

### hdl/wpm_checker.sv
`include "wake_phrase_matcher_stripper_defines.svh"

module wpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       result_kind,
  input logic [7:0] out_byte,
  input logic       addressed,
  input logic       last_result
);

  // A verdict closes the run and carries no byte
  `WPM_ALWAYS(a_verdict_last, !(out_valid && result_kind) || (last_result && out_byte == 8'h00), "verdict not last or carries a byte")

  // Byte results never claim the verdict flag
  `WPM_ALWAYS(a_byte_flag, !(out_valid && !result_kind) || !addressed, "byte result flagged addressed")

  // A stalled result holds
  `WPM_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(result_kind), "stalled result changed")

endmodule

bind wake_phrase_matcher_stripper wpm_checker u_checker (
  .clk(clk), .rst(rst),
  .out_valid(result_out.valid), .out_ready(result_out.ready),
  .result_kind(result_out.result_kind), .out_byte(result_out.out_byte),
  .addressed(result_out.addressed), .last_result(result_out.last_result)
);

### bench/wake_phrase_matcher_stripper_tb.sv
module wake_phrase_matcher_stripper_tb;
  import wpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW      = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 40;
  localparam int TARGET_BYTES = 100;

  localparam logic KIND_TEXT    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {PH_PREFIX, PH_STRIP, PH_RAW, PH_MATCHED} phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] b;
    logic       addr;
    logic       last;
  } result_t;

  logic clk;
  logic rst;

  wpm_in_if  text_in ();
  wpm_out_if result_out ();

  wake_phrase_matcher_stripper DUT (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in.sink),
    .result_out(result_out.source)
  );

  text_item_t text_q[$];
  result_t    expected_q[$];
  int         mismatches;
  int         bytes_sent;
  int         cycles;

  // Tracker of the block's state
  phase_t     ph;
  logic [7:0] pfx_buf [12];
  int         pfx_cnt;
  logic [8:0] cand;
  logic [7:0] sep_buf [2];
  int         sep_cnt;
  logic [7:0] fold_win [WINDOW];
  int         fold_fill;
  logic       phrase_hit;

  task automatic clear_tracker();
    ph         = PH_PREFIX;
    pfx_cnt    = 0;
    cand       = '1;
    sep_cnt    = 0;
    fold_fill  = 0;
    phrase_hit = 1'b0;
    for (int i = 0; i < WINDOW; i++) fold_win[i] = 8'h00;
  endtask

  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  function automatic logic same_char(input logic [7:0] a, input logic [7:0] b);
    if (a < 8'h80 && b < 8'h80) return lower_ascii(a) == lower_ascii(b);
    return a == b;
  endfunction

  function automatic logic sep_char(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h2C || b == 8'h2E || b == 8'h21 || b == 8'h3F;
  endfunction

  function automatic logic fold_dropped(input logic [7:0] b);
    return sep_char(b) || b == 8'h3A || b == 8'h3B || b == 8'h27 || b == 8'h22;
  endfunction

  function automatic result_t text_result(input logic [7:0] b);
    result_t r;
    r.kind = KIND_TEXT;
    r.b    = b;
    r.addr = 1'b0;
    r.last = 1'b0;
    return r;
  endfunction

  // Shift one folded byte in and search for the phrases
  task automatic fold_in(input logic [7:0] b);
    logic ok;
    if (fold_dropped(b)) return;
    for (int i = 0; i < WINDOW - 1; i++) fold_win[i] = fold_win[i+1];
    fold_win[WINDOW-1] = lower_ascii(b);
    if (fold_fill < WINDOW) fold_fill++;
    for (int k = 0; k < NUM_FOLD; k++) begin
      if (FOLD_LEN[k] <= fold_fill) begin
        ok = 1'b1;
        for (int j = 0; j < FOLD_LEN[k]; j++)
          if (fold_win[WINDOW - FOLD_LEN[k] + j] != FOLD_PAT[k][j]) ok = 1'b0;
        if (ok) phrase_hit = 1'b1;
      end
    end
  endtask

  // Work out the results one text byte releases
  task automatic predict_text_byte(input logic [7:0] b, input logic eot);
    result_t    outs[$];
    result_t    v;
    int         p;
    int         hit;
    logic [7:0] want;
    logic       pass_on;
    fold_in(b);
    if (ph == PH_PREFIX) begin
      p = pfx_cnt;
      hit = -1;
      for (int i = 0; i < NUM_RAW; i++)
        if (cand[i] && (p >= RAW_LEN[i] || !same_char(b, RAW_PAT[i][p]))) cand[i] = 1'b0;
      for (int i = 0; i < NUM_RAW; i++)
        if (hit < 0 && cand[i] && RAW_LEN[i] == p + 1) hit = i;
      if (hit >= 0) begin
        ph = PH_STRIP;
      end else if (cand == '0 || p >= 11) begin
        for (int i = 0; i < p; i++) outs = {outs, text_result(pfx_buf[i])};
        outs = {outs, text_result(b)};
        ph = PH_RAW;
      end else begin
        pfx_buf[p] = b;
        pfx_cnt = p + 1;
        if (eot)
          for (int i = 0; i <= p; i++) outs = {outs, text_result(pfx_buf[i])};
      end
    end else if (ph == PH_STRIP) begin
      pass_on = 1'b0;
      if (sep_cnt == 0) begin
        if (sep_char(b)) begin
        end else if (b == SEP_LEAD_A || b == SEP_LEAD_B) begin
          sep_buf[0] = b;
          sep_cnt = 1;
        end else begin
          pass_on = 1'b1;
        end
      end else if (sep_cnt == 1) begin
        want = (sep_buf[0] == SEP_LEAD_A) ? SEP_MID_A : SEP_MID_B;
        if (b == want) begin
          sep_buf[1] = b;
          sep_cnt = 2;
        end else begin
          pass_on = 1'b1;
        end
      end else begin
        want = (sep_buf[0] == SEP_LEAD_A) ? SEP_TAIL_A : SEP_TAIL_B;
        if (b == want) sep_cnt = 0;
        else pass_on = 1'b1;
      end
      if (pass_on || eot) begin
        for (int i = 0; i < sep_cnt; i++) outs = {outs, text_result(sep_buf[i])};
        sep_cnt = 0;
      end
      if (pass_on) begin
        outs = {outs, text_result(b)};
        ph = PH_MATCHED;
      end
    end else begin
      outs = {outs, text_result(b)};
    end
    if (eot) begin
      v.kind = KIND_VERDICT;
      v.b    = 8'h00;
      v.addr = (ph == PH_STRIP || ph == PH_MATCHED || phrase_hit);
      v.last = 1'b0;
      outs = {outs, v};
      clear_tracker();
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    expected_q = {expected_q, outs};
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Queue one text, marking its final byte
  task automatic add_text(input logic [7:0] bytes[$]);
    text_item_t t;
    foreach (bytes[i]) begin
      t.b   = bytes[i];
      t.eot = (i == bytes.size() - 1);
      text_q = {text_q, t};
    end
  endtask

  task automatic add_prefix(inout logic [7:0] bytes[$], input int k);
    logic [7:0] c;
    for (int j = 0; j < RAW_LEN[k]; j++) begin
      c = RAW_PAT[k][j];
      if (lower_ascii(c) >= 8'h61 && lower_ascii(c) <= 8'h7A && $urandom_range(0, 1))
        c = c ^ 8'h20;
      bytes = {bytes, c};
    end
  endtask

  task automatic add_separators(inout logic [7:0] bytes[$]);
    logic [7:0] plain [6] = '{8'h20, 8'h09, 8'h2C, 8'h2E, 8'h21, 8'h3F};
    int n;
    n = $urandom_range(0, 3);
    for (int s = 0; s < n; s++) begin
      case ($urandom_range(0, 5))
        0: begin
          bytes = {bytes, SEP_LEAD_A, SEP_MID_A, SEP_TAIL_A};
        end
        1: begin
          bytes = {bytes, SEP_LEAD_B, SEP_MID_B, SEP_TAIL_B};
        end
        2: begin
          bytes = {bytes, ($urandom_range(0, 1) ? SEP_LEAD_A : SEP_LEAD_B)};
          if ($urandom_range(0, 1))
            bytes = {bytes, ($urandom_range(0, 1) ? SEP_MID_A : SEP_MID_B)};
        end
        default: bytes = {bytes, plain[$urandom_range(0, 5)]};
      endcase
    end
  endtask

  task automatic add_tail(inout logic [7:0] bytes[$]);
    int n;
    int k;
    logic [7:0] drops [5] = '{8'h20, 8'h3A, 8'h3B, 8'h27, 8'h22};
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, NUM_FOLD - 1);
      for (int j = 0; j < FOLD_LEN[k]; j++) begin
        if ($urandom_range(0, 4) == 0) bytes = {bytes, drops[$urandom_range(0, 4)]};
        bytes = {bytes, FOLD_PAT[k][j]};
      end
    end
    n = $urandom_range(0, 5);
    for (int j = 0; j < n; j++)
      bytes = {bytes, ($urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7A))
                                            : 8'($urandom_range(0, 255)))};
  endtask

  task automatic build_stimulus();
    logic [7:0] bytes[$];
    int target;
    // Prefix in upper case, then a cut-off wide comma and a letter
    bytes = '{8'h4E, 8'h49, 8'h20, 8'h48, 8'h41, 8'h4F, 8'h20, 8'h4B, 8'h49, 8'h54,
              8'h54, 8'h59, SEP_LEAD_B, SEP_MID_B, 8'h78};
    add_text(bytes);
    // Short text that could still start a prefix
    bytes = '{8'h6E, 8'h69};
    add_text(bytes);
    // Single-byte texts at the byte extremes
    bytes = '{8'hFF};
    add_text(bytes);
    bytes = '{8'h00};
    add_text(bytes);
    // Prefix and separators only
    bytes = '{8'h6E, 8'h69, 8'h68, 8'h61, 8'h6F, 8'h20, 8'h6B, 8'h69, 8'h74, 8'h74, 8'h79,
              8'h21, SEP_LEAD_A, SEP_MID_A, SEP_TAIL_A};
    add_text(bytes);
    // Random texts: mostly prefixed, some noise or corrupted prefixes
    target = TARGET_BYTES;
    while (text_q.size() < target) begin
      bytes = {};
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 6)) bytes = {bytes, 8'($urandom_range(0, 255))};
      end else begin
        add_prefix(bytes, $urandom_range(0, NUM_RAW - 1));
        if ($urandom_range(0, 4) == 0)
          bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 6) == 0)
          bytes = bytes[0:$urandom_range(0, bytes.size() - 1)];
        add_separators(bytes);
        add_tail(bytes);
      end
      add_text(bytes);
    end
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive text bytes from the pending queue
  int in_gap;
  always @(posedge clk) begin
    logic took;
    took = text_in.valid && text_in.ready;
    if (rst) begin
      text_in.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (took) begin
        predict_text_byte(text_in.text_byte, text_in.end_of_text);
        void'(text_q.pop_front());
        bytes_sent++;
        in_gap = draw_gap();
      end
      if (!text_in.valid || took) begin
        if (in_gap > 0) begin
          in_gap--;
          text_in.valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          text_in.valid       <= 1'b1;
          text_in.text_byte   <= text_q[0].b;
          text_in.end_of_text <= text_q[0].eot;
        end else begin
          text_in.valid <= 1'b0;
        end
      end
    end
  end

  // Hold off the receiver once for a long stretch
  int  hold_left;
  bit  hold_done;
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_sent >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Check results and drive ready
  int out_stall;
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      result_out.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (result_out.result_kind !== e.kind)
            report_mismatch($sformatf("result_kind %b, want %b", result_out.result_kind, e.kind));
          if (result_out.out_byte !== e.b)
            report_mismatch($sformatf("out_byte %h, want %h", result_out.out_byte, e.b));
          if (result_out.addressed !== e.addr)
            report_mismatch($sformatf("addressed %b, want %b", result_out.addressed, e.addr));
          if (result_out.last_result !== e.last)
            report_mismatch($sformatf("last_result %b, want %b", result_out.last_result, e.last));
        end
        out_stall = draw_gap();
      end
      if (out_stall > 0) begin
        out_stall--;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= (hold_left == 0);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("wake_phrase_matcher_stripper_tb failed");
      $finish;
    end
  end

  initial begin
    text_in.valid       = 1'b0;
    text_in.text_byte   = 8'h00;
    text_in.end_of_text = 1'b0;
    result_out.ready    = 1'b0;
    mismatches = 0;
    bytes_sent = 0;
    cycles     = 0;
    clear_tracker();
    build_stimulus();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (text_q.size() == 0 && !text_in.valid);
    wait (expected_q.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("wake_phrase_matcher_stripper_tb passed");
    end else begin
      $display("wake_phrase_matcher_stripper_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/wpm_pkg.sv
hdl/wpm_in_if.sv
hdl/wpm_out_if.sv
hdl/wpm_front.sv
hdl/wpm_queue.sv
hdl/wpm_back.sv
hdl/wake_phrase_matcher_stripper.sv
hdl/wpm_checker.sv
bench/wake_phrase_matcher_stripper_tb.sv
